FILE: src/bti_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear table interpolator package
// Shared types and constants for the interpolator core and its submodules.
// ----------------------------------------------------------------------------
package bti_pkg;

   // Commands carried by an input item.
   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_VALUE  = 2'd1,
      CMD_XSLOPE = 2'd2,
      CMD_YSLOPE = 2'd3
   } cmd_type;

   // Status codes carried by a result item.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_X_RANGE = 2'd1,
      ST_Y_RANGE = 2'd2
   } status_type;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_ORIGIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_ORIGIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_INV     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_INV     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_COUNT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_COUNT   = 3'd5;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned LIDX_W  = 6;

   // Reset values of the configuration registers.
   localparam logic [DATA_W-1:0]  INV_RESET   = 32'd65536;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

   // Configuration register set.
   typedef struct packed {
      logic signed [DATA_W-1:0] x_origin;
      logic signed [DATA_W-1:0] y_origin;
      logic [DATA_W-1:0]        x_inv_spacing;
      logic [DATA_W-1:0]        y_inv_spacing;
      logic [COUNT_W-1:0]       x_count;
      logic [COUNT_W-1:0]       y_count;
   } cfg_type;

   // Sideband of a located item, aligned with the table read.
   typedef struct packed {
      logic              valid;
      cmd_type           cmd;
      status_type        status;
      logic              ix0;
      logic              iy0;
      logic [FRAC_W-1:0] fx;
      logic [FRAC_W-1:0] fy;
   } loc_type;

endpackage

FILE: src/bti_if.sv
// ----------------------------------------------------------------------------
// Interpolator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface bti_req_if;
   logic                               valid;
   logic                               ready;
   bti_pkg::cmd_type                   command;
   logic signed [bti_pkg::DATA_W-1:0]  x_coord;
   logic signed [bti_pkg::DATA_W-1:0]  y_coord;
   logic [bti_pkg::LIDX_W-1:0]         load_x_index;
   logic [bti_pkg::LIDX_W-1:0]         load_y_index;
   logic signed [bti_pkg::DATA_W-1:0]  load_value;

   modport source (output valid, command, x_coord, y_coord, load_x_index,
                   load_y_index, load_value, input ready);
   modport sink   (input valid, command, x_coord, y_coord, load_x_index,
                   load_y_index, load_value, output ready);
endinterface

interface bti_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bti_pkg::DATA_W-1:0]  result_value;
   bti_pkg::status_type                status;

   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

FILE: src/bti_locate.sv
// ----------------------------------------------------------------------------
// Cell locator
// Computes coordinate offsets, scales them by the inverse spacing, checks
// the range and forms the banked table addresses and the load write.
// ----------------------------------------------------------------------------
module bti_locate #(
   parameter int unsigned MAX_X_POINTS = 64,
   parameter int unsigned MAX_Y_POINTS = 64,
   parameter int unsigned XA_W = 5,
   parameter int unsigned YA_W = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  bti_pkg::cmd_type                    in_cmd,
   input  logic signed [bti_pkg::DATA_W-1:0]   in_x,
   input  logic signed [bti_pkg::DATA_W-1:0]   in_y,
   input  logic [bti_pkg::LIDX_W-1:0]          in_lx,
   input  logic [bti_pkg::LIDX_W-1:0]          in_ly,
   input  logic signed [bti_pkg::DATA_W-1:0]   in_lval,
   input  bti_pkg::cfg_type                    cfg,
   output bti_pkg::loc_type                    loc,
   output logic [XA_W+YA_W-1:0]                rd_addr [4],
   output logic                                wr_en,
   output logic [1:0]                          wr_bank,
   output logic [XA_W+YA_W-1:0]                wr_addr,
   output logic signed [bti_pkg::DATA_W-1:0]   wr_data
);

   localparam int unsigned IX_W = (MAX_X_POINTS > 2) ? $clog2(MAX_X_POINTS) : 1;
   localparam int unsigned IY_W = (MAX_Y_POINTS > 2) ? $clog2(MAX_Y_POINTS) : 1;
   localparam logic [10:0] MAXX = 11'(MAX_X_POINTS);
   localparam logic [10:0] MAXY = 11'(MAX_Y_POINTS);

   // Clamped count minus two: the highest cell index allowed.
   function automatic logic [10:0] cell_limit(input logic [bti_pkg::COUNT_W-1:0] cnt,
                                              input logic [10:0] maxv);
      logic [10:0] c;
      begin
         c = 11'(cnt);
         if (c < 11'd2) begin
            c = 11'd2;
         end else if (c > maxv) begin
            c = maxv;
         end
         return c - 11'd2;
      end
   endfunction

   // Stage 1: offsets from the origins.
   logic                              s1_valid_ff;
   bti_pkg::cmd_type                  s1_cmd_ff;
   logic signed [bti_pkg::DATA_W:0]   s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic [bti_pkg::LIDX_W-1:0]        s1_lx_ff, s1_ly_ff;
   logic signed [bti_pkg::DATA_W-1:0] s1_lval_ff;

   assign s1_dx_in = $signed({in_x[bti_pkg::DATA_W-1], in_x})
                   - $signed({cfg.x_origin[bti_pkg::DATA_W-1], cfg.x_origin});
   assign s1_dy_in = $signed({in_y[bti_pkg::DATA_W-1], in_y})
                   - $signed({cfg.y_origin[bti_pkg::DATA_W-1], cfg.y_origin});

   // Stage 2: scaled offsets in Q32.32.
   logic                              s2_valid_ff;
   bti_pkg::cmd_type                  s2_cmd_ff;
   logic [2*bti_pkg::DATA_W-1:0]      s2_nx_ff, s2_ny_ff, s2_nx_in, s2_ny_in;
   logic                              s2_negx_ff, s2_negy_ff;
   logic [bti_pkg::LIDX_W-1:0]        s2_lx_ff, s2_ly_ff;
   logic signed [bti_pkg::DATA_W-1:0] s2_lval_ff;

   assign s2_nx_in = s1_dx_ff[bti_pkg::DATA_W-1:0] * cfg.x_inv_spacing;
   assign s2_ny_in = s1_dy_ff[bti_pkg::DATA_W-1:0] * cfg.y_inv_spacing;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Payload of stages 1 and 2.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff  <= in_cmd;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_lx_ff   <= in_lx;
         s1_ly_ff   <= in_ly;
         s1_lval_ff <= in_lval;
         s2_cmd_ff  <= s1_cmd_ff;
         s2_nx_ff   <= s2_nx_in;
         s2_ny_ff   <= s2_ny_in;
         s2_negx_ff <= s1_dx_ff[bti_pkg::DATA_W];
         s2_negy_ff <= s1_dy_ff[bti_pkg::DATA_W];
         s2_lx_ff   <= s1_lx_ff;
         s2_ly_ff   <= s1_ly_ff;
         s2_lval_ff <= s1_lval_ff;
      end
   end

   // Stage 3 (combinational): range check and cell indexes.
   logic [bti_pkg::DATA_W-1:0] ixw, iyw;
   logic                       xbad, ybad;
   logic [IX_W-1:0]            ix, ix1;
   logic [IY_W-1:0]            iy, iy1;
   logic [XA_W-1:0]            xa [2];
   logic [YA_W-1:0]            ya [2];

   assign ixw  = s2_nx_ff[2*bti_pkg::DATA_W-1:bti_pkg::DATA_W];
   assign iyw  = s2_ny_ff[2*bti_pkg::DATA_W-1:bti_pkg::DATA_W];
   assign xbad = s2_negx_ff || (ixw > 32'(cell_limit(cfg.x_count, MAXX)));
   assign ybad = s2_negy_ff || (iyw > 32'(cell_limit(cfg.y_count, MAXY)));
   assign ix   = ixw[IX_W-1:0];
   assign iy   = iyw[IY_W-1:0];
   assign ix1  = ix + IX_W'(1);
   assign iy1  = iy + IY_W'(1);

   always_comb begin
      loc.valid = s2_valid_ff;
      loc.cmd   = s2_cmd_ff;
      loc.ix0   = ix[0];
      loc.iy0   = iy[0];
      loc.fx    = s2_nx_ff[bti_pkg::DATA_W-1:bti_pkg::FRAC_W];
      loc.fy    = s2_ny_ff[bti_pkg::DATA_W-1:bti_pkg::FRAC_W];
      if (s2_cmd_ff == bti_pkg::CMD_LOAD) begin
         loc.status = bti_pkg::ST_OK;
      end else if (xbad) begin
         loc.status = bti_pkg::ST_X_RANGE;
      end else if (ybad) begin
         loc.status = bti_pkg::ST_Y_RANGE;
      end else begin
         loc.status = bti_pkg::ST_OK;
      end
   end

   // Each bank holds one parity of x and y; pick the half index per bank.
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         xa[b] = (ix[0] == b[0]) ? XA_W'(ix >> 1) : XA_W'(ix1 >> 1);
         ya[b] = (iy[0] == b[0]) ? YA_W'(iy >> 1) : YA_W'(iy1 >> 1);
      end
      for (int k = 0; k < 4; k++) begin
         rd_addr[k] = {xa[k/2], ya[k%2]};
      end
   end

   // Table write for a load item.
   assign wr_en   = s2_valid_ff && (s2_cmd_ff == bti_pkg::CMD_LOAD)
                 && (11'(s2_lx_ff) < MAXX) && (11'(s2_ly_ff) < MAXY);
   assign wr_bank = {s2_lx_ff[0], s2_ly_ff[0]};
   assign wr_addr = {XA_W'(s2_lx_ff >> 1), YA_W'(s2_ly_ff >> 1)};
   assign wr_data = s2_lval_ff;

endmodule

FILE: src/bti_table.sv
// ----------------------------------------------------------------------------
// Banked sample table
// Four banks split by the parity of x and y, so the four corners of a cell
// are read in the same cycle. Read data is registered.
// ----------------------------------------------------------------------------
module bti_table #(
   parameter int unsigned ADDR_W = 10
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [ADDR_W-1:0]                  rd_addr [4],
   input  logic                               wr_en,
   input  logic [1:0]                         wr_bank,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic signed [bti_pkg::DATA_W-1:0]  wr_data,
   output logic signed [bti_pkg::DATA_W-1:0]  rd_data [4]
);

   localparam int unsigned DEPTH = 1 << ADDR_W;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic signed [bti_pkg::DATA_W-1:0] mem [DEPTH];
      logic signed [bti_pkg::DATA_W-1:0] rd_ff;

      // One write port and one registered read port per bank.
      always_ff @(posedge clock) begin
         if (en) begin
            if (wr_en && (wr_bank == 2'(b))) begin
               mem[wr_addr] <= wr_data;
            end
            rd_ff <= mem[rd_addr[b]];
         end
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

FILE: src/bti_arith.sv
// ----------------------------------------------------------------------------
// Interpolation datapath
// Selects the cell corners, forms the inner interpolation or slope and the
// outer interpolation, then saturates into the result register.
// ----------------------------------------------------------------------------
module bti_arith (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  bti_pkg::loc_type                   loc,
   input  logic signed [bti_pkg::DATA_W-1:0]  rd_data [4],
   input  bti_pkg::cfg_type                   cfg,
   output logic                               out_valid,
   output logic signed [bti_pkg::DATA_W-1:0]  out_value,
   output bti_pkg::status_type                out_status
);

   localparam int unsigned DW = bti_pkg::DATA_W;
   localparam int unsigned FW = bti_pkg::FRAC_W;
   localparam int unsigned PW = 2 * (DW + 1) - FW;   // scaled inner product
   localparam int unsigned EW = PW + 1;              // inner result
   localparam int unsigned QW = EW + 1;              // scaled outer product
   localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   // Stage A: located item aligned with the table read data.
   bti_pkg::loc_type a_ff;

   // Stage B: corners paired and differenced, inner multiplier chosen.
   logic                 b_valid_ff;
   bti_pkg::status_type  b_status_ff;
   logic                 b_add_ff, b_add_in;
   logic signed [DW-1:0] b_a0_ff, b_a1_ff, b_a0_in, b_a1_in;
   logic signed [DW:0]   b_d0_ff, b_d1_ff, b_d0_in, b_d1_in;
   logic signed [DW:0]   b_m_ff, b_m_in;
   logic [FW-1:0]        b_fo_ff, b_fo_in;
   logic signed [DW-1:0] f00, f10, f01, f11;

   // Stage C: inner products.
   logic                 c_valid_ff;
   bti_pkg::status_type  c_status_ff;
   logic                 c_add_ff;
   logic signed [DW-1:0] c_a0_ff, c_a1_ff;
   logic signed [PW-1:0] c_p0_ff, c_p1_ff;
   logic signed [2*DW+1:0] c_p0_full, c_p1_full;
   logic [FW-1:0]        c_fo_ff;

   // Stage D: inner results and their difference.
   logic                 d_valid_ff;
   bti_pkg::status_type  d_status_ff;
   logic signed [EW-1:0] d_e0_ff, d_e0_in, d_e1_in;
   logic signed [EW:0]   d_df_ff, d_df_in;
   logic [FW-1:0]        d_fo_ff;

   // Stage E: outer product.
   logic                 e_valid_ff;
   bti_pkg::status_type  e_status_ff;
   logic signed [EW-1:0] e_e0_ff;
   logic signed [QW-1:0] e_q_ff;
   logic signed [EW+FW+1:0] e_q_full;

   // Stage F: result register.
   logic                 f_valid_ff;
   bti_pkg::status_type  f_status_ff;
   logic signed [DW-1:0] f_value_ff, f_value_in;
   logic signed [QW:0]   f_sum;

   // Corner selection by cell parity: bank index is {x parity, y parity}.
   assign f00 = rd_data[{a_ff.ix0, a_ff.iy0}];
   assign f10 = rd_data[{~a_ff.ix0, a_ff.iy0}];
   assign f01 = rd_data[{a_ff.ix0, ~a_ff.iy0}];
   assign f11 = rd_data[{~a_ff.ix0, ~a_ff.iy0}];

   // Pair the corners for the inner step and pick its multiplier.
   always_comb begin
      b_add_in = (a_ff.cmd == bti_pkg::CMD_VALUE);
      if (a_ff.cmd == bti_pkg::CMD_YSLOPE) begin
         b_a0_in = f00;
         b_a1_in = f10;
         b_d0_in = $signed({f01[DW-1], f01}) - $signed({f00[DW-1], f00});
         b_d1_in = $signed({f11[DW-1], f11}) - $signed({f10[DW-1], f10});
         b_m_in  = $signed({1'b0, cfg.y_inv_spacing});
         b_fo_in = a_ff.fx;
      end else begin
         b_a0_in = f00;
         b_a1_in = f01;
         b_d0_in = $signed({f10[DW-1], f10}) - $signed({f00[DW-1], f00});
         b_d1_in = $signed({f11[DW-1], f11}) - $signed({f01[DW-1], f01});
         if (b_add_in) begin
            b_m_in = $signed({{(DW+1-FW){1'b0}}, a_ff.fx});
         end else begin
            b_m_in = $signed({1'b0, cfg.x_inv_spacing});
         end
         b_fo_in = a_ff.fy;
      end
   end

   // Inner products, floored by the arithmetic part-select.
   assign c_p0_full = b_d0_ff * b_m_ff;
   assign c_p1_full = b_d1_ff * b_m_ff;

   // Inner results: interpolation adds the base corner, slopes do not.
   assign d_e0_in = (c_add_ff ? EW'(c_a0_ff) : EW'(0)) + EW'(c_p0_ff);
   assign d_e1_in = (c_add_ff ? EW'(c_a1_ff) : EW'(0)) + EW'(c_p1_ff);
   assign d_df_in = (EW+1)'(d_e1_in) - (EW+1)'(d_e0_in);

   // Outer product with the outer fraction.
   assign e_q_full = d_df_ff * $signed({1'b0, d_fo_ff});

   // Final sum and saturation; errors and loads give zero.
   assign f_sum = (QW+1)'(e_e0_ff) + (QW+1)'(e_q_ff);
   always_comb begin
      if (e_status_ff != bti_pkg::ST_OK) begin
         f_value_in = '0;
      end else if (f_sum > (QW+1)'(SAT_MAX)) begin
         f_value_in = SAT_MAX;
      end else if (f_sum < (QW+1)'(SAT_MIN)) begin
         f_value_in = SAT_MIN;
      end else begin
         f_value_in = f_sum[DW-1:0];
      end
   end

   // Stage A register: the located item and its valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (en) begin
         a_ff <= loc;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_ff.valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         b_status_ff <= a_ff.status;
         b_add_ff    <= b_add_in;
         // A load or an out-of-range item clears its operands so the result
         // comes out zero.
         if (a_ff.cmd == bti_pkg::CMD_LOAD || a_ff.status != bti_pkg::ST_OK) begin
            b_d0_ff <= '0;
            b_d1_ff <= '0;
            b_a0_ff <= '0;
            b_a1_ff <= '0;
         end else begin
            b_d0_ff <= b_d0_in;
            b_d1_ff <= b_d1_in;
            b_a0_ff <= b_a0_in;
            b_a1_ff <= b_a1_in;
         end
         b_m_ff      <= b_m_in;
         b_fo_ff     <= b_fo_in;
         c_status_ff <= b_status_ff;
         c_add_ff    <= b_add_ff;
         c_a0_ff     <= b_a0_ff;
         c_a1_ff     <= b_a1_ff;
         c_p0_ff     <= c_p0_full[2*DW+1:FW];
         c_p1_ff     <= c_p1_full[2*DW+1:FW];
         c_fo_ff     <= b_fo_ff;
         d_status_ff <= c_status_ff;
         d_e0_ff     <= d_e0_in;
         d_df_ff     <= d_df_in;
         d_fo_ff     <= c_fo_ff;
         e_status_ff <= d_status_ff;
         e_e0_ff     <= d_e0_ff;
         e_q_ff      <= e_q_full[QW+FW-1:FW];
         f_status_ff <= e_status_ff;
         f_value_ff  <= f_value_in;
      end
   end

   assign out_valid  = f_valid_ff;
   assign out_value  = f_value_ff;
   assign out_status = f_status_ff;

endmodule

FILE: src/bilinear_table_interpolator_core.sv
// A request item passes locator stages 1 and 2, stage A with the table read, then B to F.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Four corner reads come from four parity banks in the same cycle, so no item waits.
// Reset clears the valid bits and the configuration registers to their
// defaults; the sample table is not cleared and holds what loads wrote.
// ----------------------------------------------------------------------------
// Bilinear table interpolator core
// Uniform 2-D Q16.16 sample table with value and slope queries.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator_core #(
   parameter int unsigned MAX_X_POINTS = 64,
   parameter int unsigned MAX_Y_POINTS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   bti_req_if.sink                               req_bus,
   bti_rsp_if.source                             rsp_bus,
   input  logic                                  csr_write_en,
   input  logic [bti_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bti_pkg::DATA_W-1:0]            csr_wdata
);

   localparam int unsigned XH   = (MAX_X_POINTS + 1) / 2;
   localparam int unsigned YH   = (MAX_Y_POINTS + 1) / 2;
   localparam int unsigned XA_W = (XH > 1) ? $clog2(XH) : 1;
   localparam int unsigned YA_W = (YH > 1) ? $clog2(YH) : 1;
   localparam int unsigned AW   = XA_W + YA_W;

   bti_pkg::cfg_type                  cfg_ff;
   bti_pkg::loc_type                  loc;
   logic [AW-1:0]                     rd_addr [4];
   logic                              wr_en;
   logic [1:0]                        wr_bank;
   logic [AW-1:0]                     wr_addr;
   logic signed [bti_pkg::DATA_W-1:0] wr_data;
   logic signed [bti_pkg::DATA_W-1:0] rd_data [4];
   logic                              en;
   logic                              out_valid;

   // The pipeline moves whenever the result register is free or being taken.
   assign en            = !out_valid || rsp_bus.ready;
   assign req_bus.ready = en;
   assign rsp_bus.valid = out_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin      <= '0;
         cfg_ff.y_origin      <= '0;
         cfg_ff.x_inv_spacing <= bti_pkg::INV_RESET;
         cfg_ff.y_inv_spacing <= bti_pkg::INV_RESET;
         cfg_ff.x_count       <= bti_pkg::COUNT_RESET;
         cfg_ff.y_count       <= bti_pkg::COUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            bti_pkg::CSR_X_ORIGIN: cfg_ff.x_origin      <= csr_wdata;
            bti_pkg::CSR_Y_ORIGIN: cfg_ff.y_origin      <= csr_wdata;
            bti_pkg::CSR_X_INV:    cfg_ff.x_inv_spacing <= csr_wdata;
            bti_pkg::CSR_Y_INV:    cfg_ff.y_inv_spacing <= csr_wdata;
            bti_pkg::CSR_X_COUNT:  cfg_ff.x_count <= csr_wdata[bti_pkg::COUNT_W-1:0];
            bti_pkg::CSR_Y_COUNT:  cfg_ff.y_count <= csr_wdata[bti_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   bti_locate #(
      .MAX_X_POINTS (MAX_X_POINTS),
      .MAX_Y_POINTS (MAX_Y_POINTS),
      .XA_W         (XA_W),
      .YA_W         (YA_W)
   ) u_locate (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_bus.valid),
      .in_cmd   (req_bus.command),
      .in_x     (req_bus.x_coord),
      .in_y     (req_bus.y_coord),
      .in_lx    (req_bus.load_x_index),
      .in_ly    (req_bus.load_y_index),
      .in_lval  (req_bus.load_value),
      .cfg      (cfg_ff),
      .loc      (loc),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_bank  (wr_bank),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   bti_table #(
      .ADDR_W (AW)
   ) u_table (
      .clock   (clock),
      .en      (en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_bank (wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   bti_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .loc        (loc),
      .rd_data    (rd_data),
      .cfg        (cfg_ff),
      .out_valid  (out_valid),
      .out_value  (rsp_bus.result_value),
      .out_status (rsp_bus.status)
   );

endmodule
